// ===== sv/face_rotation_coverage_tracker_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef FACE_ROTATION_COVERAGE_TRACKER_UNIT_ASSERT_SVH
`define FACE_ROTATION_COVERAGE_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FRCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frct check failed");

// next-cycle implication, disabled during reset
`define FRCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frct check failed");

`endif

// ===== sv/frct_pkg.sv =====
`default_nettype none
package frct_pkg;

  // request kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // face codes
  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_FRONT  = 3'd2;
  localparam logic [2:0] FACE_BACK   = 3'd3;
  localparam logic [2:0] FACE_LEFT   = 3'd4;
  localparam logic [2:0] FACE_RIGHT  = 3'd5;
  localparam int unsigned NUM_FACES  = 6;
  localparam logic [5:0] ALL_DONE    = 6'h3F;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_RATE  = 2'd0;
  localparam logic [1:0] CFG_MAX_RATE  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_MAX_SAMP  = 2'd3;

  // field widths
  localparam int unsigned RATE_W = 15;
  localparam int unsigned THR_W  = 40;
  localparam int unsigned SAMP_W = 16;
  localparam int unsigned CFG_W  = 40;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned SUM_W  = THR_W + 3;

  // configuration reset values
  localparam logic [RATE_W-1:0] MIN_RATE_RST  = 15'd410;
  localparam logic [RATE_W-1:0] MAX_RATE_RST  = 15'd4096;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 40'd51471854000;
  localparam logic [SAMP_W-1:0] MAX_SAMP_RST  = 16'd4096;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT0,
    S_DOT1,
    S_DOT2,
    S_DOT3,
    S_ABS,
    S_CLAMP,
    S_MUL,
    S_ADD,
    S_CHECK,
    S_SUM,
    S_DIVGO,
    S_DIV,
    S_FIN
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_stat_t;

  // upward face from the world-Z row; x wins ties, then y
  function automatic logic [2:0] pick_face(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z);
    logic [16:0] ax;
    logic [16:0] ay;
    logic [16:0] az;
    logic [2:0]  f;
    ax = x[15] ? 17'(-17'(x)) : 17'(x);
    ay = y[15] ? 17'(-17'(y)) : 17'(y);
    az = z[15] ? 17'(-17'(z)) : 17'(z);
    if (ax >= ay && ax >= az) begin
      f = (x > 16'sd0) ? FACE_FRONT : FACE_BACK;
    end else if (ay >= az) begin
      f = (y > 16'sd0) ? FACE_LEFT : FACE_RIGHT;
    end else begin
      f = (z > 16'sd0) ? FACE_TOP : FACE_BOTTOM;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== sv/frct_mul.sv =====
`default_nettype none
module frct_mul (
  input  wire                clk,
  input  wire signed [31:0]  op_a,
  input  wire signed [16:0]  op_b,
  output logic signed [48:0] prod_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= 49'(op_a) * 49'(op_b);
  end

endmodule
`default_nettype wire

// ===== sv/frct_div.sv =====
`default_nettype none
module frct_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [frct_pkg::SUM_W-1:0] sum_in,
  input  wire [frct_pkg::THR_W-1:0] thr_in,
  output frct_pkg::div_stat_t      stat
);
  import frct_pkg::*;

  localparam int unsigned NUM_W = 50;

  logic             active_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic [NUM_W-1:0] n_r;
  logic [NUM_W-1:0] dsh_r;
  logic [SUM_W-1:0] s_r;
  logic [PCT_W-1:0] q_r;
  logic             fits;
  logic [NUM_W-1:0] diff;

  assign diff = n_r - dsh_r;
  assign fits = (n_r >= dsh_r);

  // control: one scaling step then seven restoring steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // datapath: numerator is 100 * sum, divisor 6 * t shifted to the top quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      s_r   <= sum_in;
      n_r   <= (NUM_W'(sum_in) << 6) + (NUM_W'(sum_in) << 5);
      dsh_r <= (NUM_W'(thr_in) << 8) + (NUM_W'(thr_in) << 7);
      q_r   <= '0;
    end else if (active_r) begin
      if (cnt_r == 3'd0) begin
        n_r <= n_r + (NUM_W'(s_r) << 2);
      end else begin
        if (fits) begin
          n_r <= diff;
        end
        q_r   <= {q_r[PCT_W-2:0], fits};
        dsh_r <= dsh_r >> 1;
      end
    end
  end

  assign stat.done = done_r;
  assign stat.quot = q_r;

endmodule
`default_nettype wire

// ===== sv/face_rotation_coverage_tracker_unit.sv =====
// face rotation coverage tracker
// requests enter on in_valid/in_stall; in_kind selects sample, start or cancel.
// every request gives exactly one result on out_valid/out_stall.
// a sample taken while running goes through a small sequencer: three
// multiply-accumulate steps on one shared multiplier form the yaw rate, the
// same multiplier scales the clamped rate by the elapsed time, then the face
// angles are summed one face per cycle and a restoring divider forms the
// percent one quotient bit per cycle.
// a sample that needs the percent takes the full path; the sum and the divider
// are skipped once all faces are complete, and start, cancel, ignored requests
// and the sample limit go straight to the result. the input is stalled from
// the request until its result is loaded, so no new request is taken before
// the last one is through. the output register holds a finished result while
// out_stall is high; a new request is taken meanwhile, and its result waits
// until the old one leaves. reset (synchronous, rst_n low) stops collection,
// clears all face angles, counts and flags, loads the default configuration.
// configuration is written through cfg_we/cfg_index/cfg_wdata while idle; the
// user must keep to this, as the block itself does not enforce it.
`default_nettype none
module face_rotation_coverage_tracker_unit #(
  parameter int unsigned ANGLE_WIDTH = 40
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [1:0]                 in_kind,
  input  wire  signed [15:0]         in_axis_x_up,
  input  wire  signed [15:0]         in_axis_y_up,
  input  wire  signed [15:0]         in_axis_z_up,
  input  wire  signed [15:0]         in_body_rate_x,
  input  wire  signed [15:0]         in_body_rate_y,
  input  wire  signed [15:0]         in_body_rate_z,
  input  wire  [15:0]                in_elapsed_us,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic                       out_accepted,
  output logic [2:0]                 out_up_face,
  output logic [39:0]                out_face_angle,
  output logic                       out_face_complete,
  output logic [frct_pkg::PCT_W-1:0] out_total_percent,
  output logic                       out_all_complete,
  output logic                       out_limit_hit,
  input  wire                        cfg_we,
  input  wire  [1:0]                 cfg_index,
  input  wire  [frct_pkg::CFG_W-1:0] cfg_wdata
);
  import frct_pkg::*;

  localparam int unsigned AW    = ANGLE_WIDTH;
  localparam int unsigned INC_W = 34;
  localparam int unsigned SAT_W = ((AW > INC_W) ? AW : INC_W) + 1;
  localparam int unsigned CMP_W = (AW > THR_W) ? AW : THR_W;
  localparam logic [AW-1:0] AMAX = {AW{1'b1}};

  // configuration
  logic [RATE_W-1:0] min_rate_r;
  logic [RATE_W-1:0] max_rate_r;
  logic [THR_W-1:0]  thr_r;
  logic [SAMP_W-1:0] max_samp_r;

  // tracking state
  logic              running_r;
  logic [SAMP_W-1:0] count_r;
  logic [AW-1:0]     angles_r [NUM_FACES];
  logic [5:0]        done_r;

  // per-request working registers
  state_t              state_r, state_nxt;
  logic signed [15:0]  ax_r, ay_r, az_r, rx_r, ry_r, rz_r;
  logic [15:0]         dt_r;
  logic [2:0]          face_r;
  logic signed [32:0]  acc_r;
  logic [31:0]         mag_r;
  logic [30:0]         clamp_r;
  logic [SUM_W-1:0]    sum_r;
  logic [2:0]          sum_idx_r;

  // result staging and output register
  logic              res_accepted_r, res_complete_r, res_all_r, res_limit_r;
  logic [39:0]       res_angle_r;
  logic [PCT_W-1:0]  res_pct_r;
  logic              out_valid_r;

  // combinational helpers
  logic               in_acc;
  logic [2:0]         face_in;
  logic               upd_in;
  logic               do_sample;
  logic               at_limit;
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_prod;
  logic [2:0]         rd_idx;
  logic [AW-1:0]      cur_angle;
  logic signed [32:0] acc_neg;
  logic [31:0]        min_sh, max_sh;
  logic               rate_above;
  logic [INC_W-1:0]   inc;
  logic [SAT_W-1:0]   sat_sum;
  logic [AW-1:0]      new_angle;
  logic [CMP_W-1:0]   cur_ext;
  logic               over_thr;
  logic [5:0]         face_bit;
  logic [5:0]         done_new;
  logic [THR_W-1:0]   t_eff;
  logic [THR_W-1:0]   contrib;
  logic               div_start;
  div_stat_t          div_stat;
  logic               out_free;

  assign in_acc    = in_valid && !in_stall;
  assign face_in   = pick_face(in_axis_x_up, in_axis_y_up, in_axis_z_up);
  assign upd_in    = (done_r != ALL_DONE) && !done_r[face_in];
  assign do_sample = (in_kind == KIND_SAMPLE) && running_r;
  assign at_limit  = (count_r >= max_samp_r);
  assign out_free  = !(out_valid_r && out_stall);

  // rate magnitude and clamp
  assign acc_neg    = -acc_r;
  assign min_sh     = 32'({min_rate_r, 14'b0});
  assign max_sh     = 32'({max_rate_r, 14'b0});
  assign rate_above = (mag_r > min_sh);

  // saturating angle update
  assign cur_angle = angles_r[rd_idx];
  assign inc       = mul_prod[47:14];
  assign sat_sum   = SAT_W'(cur_angle) + SAT_W'(inc);
  assign new_angle = (sat_sum > SAT_W'(AMAX)) ? AMAX : sat_sum[AW-1:0];

  // completion check
  assign cur_ext  = CMP_W'(cur_angle);
  assign over_thr = (cur_ext > CMP_W'(thr_r));
  assign face_bit = 6'd1 << face_r;
  assign done_new = over_thr ? (done_r | face_bit) : done_r;

  // clamped progress of one face for the percent sum
  assign t_eff   = (thr_r == '0) ? THR_W'(1) : thr_r;
  assign contrib = done_r[sum_idx_r] ? t_eff :
                   ((cur_ext < CMP_W'(t_eff)) ? cur_ext[THR_W-1:0] : t_eff);

  frct_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_prod)
  );

  frct_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .sum_in (sum_r),
    .thr_in (t_eff),
    .stat   (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (do_sample && !at_limit) begin
            state_nxt = upd_in ? S_DOT0 : S_CHECK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DOT0:  state_nxt = S_DOT1;
      S_DOT1:  state_nxt = S_DOT2;
      S_DOT2:  state_nxt = S_DOT3;
      S_DOT3:  state_nxt = S_ABS;
      S_ABS:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = rate_above ? S_MUL : S_CHECK;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = (done_new == ALL_DONE) ? S_FIN : S_SUM;
      S_SUM:   state_nxt = (sum_idx_r == 3'(NUM_FACES - 1)) ? S_DIVGO : S_SUM;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   state_nxt = div_stat.done ? S_FIN : S_DIV;
      S_FIN:   state_nxt = out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rd_idx    = face_r;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_DOT0: begin
        mul_a = 32'(ax_r);
        mul_b = 17'(rx_r);
      end
      S_DOT1: begin
        mul_a = 32'(ay_r);
        mul_b = 17'(ry_r);
      end
      S_DOT2: begin
        mul_a = 32'(az_r);
        mul_b = 17'(rz_r);
      end
      S_MUL: begin
        mul_a = $signed({1'b0, clamp_r});
        mul_b = $signed({1'b0, dt_r});
      end
      S_SUM:   rd_idx = sum_idx_r;
      S_DIVGO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= MIN_RATE_RST;
      max_rate_r <= MAX_RATE_RST;
      thr_r      <= THRESHOLD_RST;
      max_samp_r <= MAX_SAMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_RATE:  min_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_MAX_RATE:  max_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_THRESHOLD: thr_r      <= cfg_wdata[THR_W-1:0];
        CFG_MAX_SAMP:  max_samp_r <= cfg_wdata[SAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // tracking state: clears, sample count, angle writes and face flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      count_r   <= '0;
      done_r    <= '0;
      for (int i = 0; i < NUM_FACES; i++) begin
        angles_r[i] <= '0;
      end
    end else begin
      if (state_r == S_IDLE && in_acc) begin
        if (in_kind == KIND_START || in_kind == KIND_CANCEL ||
            (do_sample && at_limit)) begin
          running_r <= (in_kind == KIND_START);
          count_r   <= '0;
          done_r    <= '0;
          for (int i = 0; i < NUM_FACES; i++) begin
            angles_r[i] <= '0;
          end
        end else if (do_sample) begin
          count_r <= count_r + 16'd1;
        end
      end
      if (state_r == S_ADD) begin
        angles_r[face_r] <= new_angle;
      end
      if (state_r == S_CHECK) begin
        done_r <= done_new;
      end
    end
  end

  // working registers and result staging
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ax_r           <= in_axis_x_up;
          ay_r           <= in_axis_y_up;
          az_r           <= in_axis_z_up;
          rx_r           <= in_body_rate_x;
          ry_r           <= in_body_rate_y;
          rz_r           <= in_body_rate_z;
          dt_r           <= (count_r == '0) ? 16'd0 : in_elapsed_us;
          face_r         <= face_in;
          res_accepted_r <= do_sample && !at_limit;
          res_limit_r    <= do_sample && at_limit;
          res_angle_r    <= '0;
          res_complete_r <= 1'b0;
          res_pct_r      <= '0;
          res_all_r      <= 1'b0;
        end
      end
      S_DOT1:  acc_r <= 33'(mul_prod);
      S_DOT2:  acc_r <= acc_r + 33'(mul_prod);
      S_DOT3:  acc_r <= acc_r + 33'(mul_prod);
      S_ABS:   mag_r <= acc_r[32] ? acc_neg[31:0] : acc_r[31:0];
      S_CLAMP: clamp_r <= (mag_r > max_sh) ? max_sh[30:0] : mag_r[30:0];
      S_CHECK: begin
        res_angle_r    <= cur_ext[39:0];
        res_complete_r <= done_new[face_r];
        sum_r          <= '0;
        sum_idx_r      <= '0;
        if (done_new == ALL_DONE) begin
          res_pct_r <= PCT_FULL;
          res_all_r <= 1'b1;
        end
      end
      S_SUM: begin
        sum_r     <= sum_r + SUM_W'(contrib);
        sum_idx_r <= sum_idx_r + 3'd1;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_pct_r <= div_stat.quot;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_accepted      <= res_accepted_r;
      out_up_face       <= res_accepted_r ? face_r : 3'd0;
      out_face_angle    <= res_angle_r;
      out_face_complete <= res_complete_r;
      out_total_percent <= res_pct_r;
      out_all_complete  <= res_all_r;
      out_limit_hit     <= res_limit_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/frct_chk.sv =====
`default_nettype none
`include "face_rotation_coverage_tracker_unit_assert.svh"
module frct_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        out_accepted,
  input wire [39:0] out_face_angle,
  input wire        out_face_complete,
  input wire [6:0]  out_total_percent,
  input wire        out_all_complete,
  input wire        out_limit_hit
);

  // a stalled result stays offered
  `FRCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // a taken request leaves the input stalled while it is worked on
  `FRCT_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // a sample-limit result carries nothing else
  `FRCT_ASSERT_NOW(a_limit_clean, clk, rst_n, out_valid && out_limit_hit, !out_accepted && out_face_angle == 40'd0 && out_total_percent == 7'd0 && !out_all_complete)

  // all faces complete reports full progress on a taken sample
  `FRCT_ASSERT_NOW(a_all_full, clk, rst_n, out_valid && out_all_complete, out_total_percent == 7'd100 && out_face_complete && out_accepted)

  // progress never passes one hundred percent
  `FRCT_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, out_total_percent <= 7'd100)

endmodule

bind face_rotation_coverage_tracker_unit frct_chk u_frct_chk (.*);
`default_nettype wire

// ===== dv/coverage_report_checker.sv =====
`timescale 1ns / 100ps

// watches the request, result and configuration ports of the coverage tracker,
// predicts one result per request and compares results in order
module coverage_report_checker
  import frct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic signed [15:0]   in_axis_x_up,
  input  logic signed [15:0]   in_axis_y_up,
  input  logic signed [15:0]   in_axis_z_up,
  input  logic signed [15:0]   in_body_rate_x,
  input  logic signed [15:0]   in_body_rate_y,
  input  logic signed [15:0]   in_body_rate_z,
  input  logic [15:0]          in_elapsed_us,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_accepted,
  input  logic [2:0]           out_up_face,
  input  logic [39:0]          out_face_angle,
  input  logic                 out_face_complete,
  input  logic [PCT_W-1:0]     out_total_percent,
  input  logic                 out_all_complete,
  input  logic                 out_limit_hit,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   reports_owed,
  output int                   mismatch_count,
  output int                   reports_checked,
  output int                   full_coverage_seen,
  output int                   limit_hits_seen
);

  // ceiling of the saturating face angle at the default angle width
  localparam longint unsigned ANGLE_MAX = (64'd1 << 40) - 64'd1;

  typedef struct packed {
    logic             accepted;
    logic [2:0]       up_face;
    logic [39:0]      face_angle;
    logic             face_complete;
    logic [PCT_W-1:0] total_percent;
    logic             all_complete;
    logic             limit_hit;
  } coverage_report_t;

  // configuration copy
  logic [RATE_W-1:0] cfg_min_rate;
  logic [RATE_W-1:0] cfg_max_rate;
  logic [THR_W-1:0]  cfg_threshold;
  logic [SAMP_W-1:0] cfg_max_samples;

  // tracker state copy
  bit                collecting;
  int unsigned       samples_taken;
  longint unsigned   face_angle_q [NUM_FACES];
  logic [5:0]        faces_done;

  coverage_report_t  expected_reports [$];
  int                errors;
  int                checked;
  int                full_seen;
  int                limit_seen;

  function automatic void clear_progress();
    collecting    = 1'b0;
    samples_taken = 0;
    faces_done    = '0;
    foreach (face_angle_q[i]) face_angle_q[i] = 0;
  endfunction

  // dominant axis of the world-z row; zero counts as the negative direction
  function automatic int unsigned upward_face(input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic signed [15:0] z);
    int mx;
    int my;
    int mz;
    mx = (x < 0) ? -int'(x) : int'(x);
    my = (y < 0) ? -int'(y) : int'(y);
    mz = (z < 0) ? -int'(z) : int'(z);
    if (mx >= my && mx >= mz) return (x > 0) ? FACE_FRONT : FACE_BACK;
    if (my >= mz) return (y > 0) ? FACE_LEFT : FACE_RIGHT;
    return (z > 0) ? FACE_TOP : FACE_BOTTOM;
  endfunction

  // floor of mean clamped progress in percent, zero threshold taken as one
  function automatic longint unsigned coverage_percent();
    longint unsigned t;
    longint unsigned total;
    t = (cfg_threshold == '0) ? 64'd1 : 64'(cfg_threshold);
    total = 0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (faces_done[i]) total += t;
      else total += (face_angle_q[i] < t) ? face_angle_q[i] : t;
    end
    return (total * 64'(PCT_FULL)) / (t * NUM_FACES);
  endfunction

  // one request in, one expected result out
  function automatic coverage_report_t track_request(input logic [1:0] kind,
                                                     input logic signed [15:0] ax,
                                                     input logic signed [15:0] ay,
                                                     input logic signed [15:0] az,
                                                     input logic signed [15:0] rx,
                                                     input logic signed [15:0] ry,
                                                     input logic signed [15:0] rz,
                                                     input logic [15:0] elapsed);
    coverage_report_t rpt;
    longint           dot;
    longint unsigned  yaw;
    longint unsigned  clamp;
    longint unsigned  gain;
    longint unsigned  dt;
    int unsigned      f;
    rpt = '0;
    if (kind == KIND_START || kind == KIND_CANCEL) begin
      clear_progress();
      collecting = (kind == KIND_START);
      return rpt;
    end
    if (kind != KIND_SAMPLE || !collecting) return rpt;

    // sample limit clears everything and stops
    if (samples_taken >= cfg_max_samples) begin
      clear_progress();
      rpt.limit_hit = 1'b1;
      return rpt;
    end

    dt = (samples_taken == 0) ? 64'd0 : 64'(elapsed);
    samples_taken++;
    f = upward_face(ax, ay, az);

    // integrate yaw on an unfinished face
    if (faces_done != ALL_DONE && !faces_done[f]) begin
      dot = longint'(ax) * longint'(rx) + longint'(ay) * longint'(ry)
          + longint'(az) * longint'(rz);
      yaw = (dot < 0) ? -dot : dot;
      if (yaw > (64'(cfg_min_rate) << 14)) begin
        clamp = 64'(cfg_max_rate) << 14;
        gain  = (((yaw < clamp) ? yaw : clamp) * dt) >> 14;
        if (gain > ANGLE_MAX - face_angle_q[f]) face_angle_q[f] = ANGLE_MAX;
        else face_angle_q[f] += gain;
      end
      if (face_angle_q[f] > 64'(cfg_threshold)) faces_done[f] = 1'b1;
    end

    rpt.accepted      = 1'b1;
    rpt.up_face       = 3'(f);
    rpt.face_angle    = 40'(face_angle_q[f]);
    rpt.face_complete = faces_done[f];
    rpt.all_complete  = (faces_done == ALL_DONE);
    rpt.total_percent = rpt.all_complete ? PCT_FULL : PCT_W'(coverage_percent());
    return rpt;
  endfunction

  function automatic bit field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin : watch_channels
    coverage_report_t want;
    bit               ok;
    if (!rst_n) begin
      cfg_min_rate    = MIN_RATE_RST;
      cfg_max_rate    = MAX_RATE_RST;
      cfg_threshold   = THRESHOLD_RST;
      cfg_max_samples = MAX_SAMP_RST;
      clear_progress();
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with no request outstanding, face %0d percent %0d limit %0b",
                   $time, out_up_face, out_total_percent, out_limit_hit);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          ok = field_ok("accepted", want.accepted, out_accepted)
             & field_ok("up_face", want.up_face, out_up_face)
             & field_ok("face_angle", want.face_angle, out_face_angle)
             & field_ok("face_complete", want.face_complete, out_face_complete)
             & field_ok("total_percent", want.total_percent, out_total_percent)
             & field_ok("all_complete", want.all_complete, out_all_complete)
             & field_ok("limit_hit", want.limit_hit, out_limit_hit);
          if (!ok) errors++;
          checked++;
          if (want.all_complete) full_seen++;
          if (want.limit_hit) limit_seen++;
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_RATE:  cfg_min_rate    = cfg_wdata[RATE_W-1:0];
          CFG_MAX_RATE:  cfg_max_rate    = cfg_wdata[RATE_W-1:0];
          CFG_THRESHOLD: cfg_threshold   = cfg_wdata[THR_W-1:0];
          CFG_MAX_SAMP:  cfg_max_samples = cfg_wdata[SAMP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        expected_reports.push_back(track_request(in_kind, in_axis_x_up, in_axis_y_up,
                                                 in_axis_z_up, in_body_rate_x,
                                                 in_body_rate_y, in_body_rate_z,
                                                 in_elapsed_us));
      end
    end
    reports_owed       <= expected_reports.size();
    mismatch_count     <= errors;
    reports_checked    <= checked;
    full_coverage_seen <= full_seen;
    limit_hits_seen    <= limit_seen;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import frct_pkg::*;

  // request kind the tracker ignores
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind = KIND_SAMPLE;
  logic signed [15:0]   in_axis_x_up = '0;
  logic signed [15:0]   in_axis_y_up = '0;
  logic signed [15:0]   in_axis_z_up = '0;
  logic signed [15:0]   in_body_rate_x = '0;
  logic signed [15:0]   in_body_rate_y = '0;
  logic signed [15:0]   in_body_rate_z = '0;
  logic [15:0]          in_elapsed_us = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic [2:0]           out_up_face;
  logic [39:0]          out_face_angle;
  logic                 out_face_complete;
  logic [PCT_W-1:0]     out_total_percent;
  logic                 out_all_complete;
  logic                 out_limit_hit;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = CFG_MIN_RATE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int reports_owed;
  int mismatch_count;
  int reports_checked;
  int full_coverage_seen;
  int limit_hits_seen;

  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int samples_sent = 0;
  int phases_run = 0;

  face_rotation_coverage_tracker_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_axis_x_up(in_axis_x_up), .in_axis_y_up(in_axis_y_up),
    .in_axis_z_up(in_axis_z_up), .in_body_rate_x(in_body_rate_x),
    .in_body_rate_y(in_body_rate_y), .in_body_rate_z(in_body_rate_z),
    .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_up_face(out_up_face), .out_face_angle(out_face_angle),
    .out_face_complete(out_face_complete), .out_total_percent(out_total_percent),
    .out_all_complete(out_all_complete), .out_limit_hit(out_limit_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  coverage_report_checker report_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_axis_x_up(in_axis_x_up), .in_axis_y_up(in_axis_y_up),
    .in_axis_z_up(in_axis_z_up), .in_body_rate_x(in_body_rate_x),
    .in_body_rate_y(in_body_rate_y), .in_body_rate_z(in_body_rate_z),
    .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_up_face(out_up_face), .out_face_angle(out_face_angle),
    .out_face_complete(out_face_complete), .out_total_percent(out_total_percent),
    .out_all_complete(out_all_complete), .out_limit_hit(out_limit_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .reports_owed(reports_owed), .mismatch_count(mismatch_count),
    .reports_checked(reports_checked), .full_coverage_seen(full_coverage_seen),
    .limit_hits_seen(limit_hits_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  initial begin
    #4_000_000;
    $display("run timed out with %0d results outstanding", reports_owed);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [15:0] rand_axis();
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] small_signed(input int span);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  // one request, after an optional idle gap, held until taken
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [15:0] ax,
                              input logic signed [15:0] ay,
                              input logic signed [15:0] az,
                              input logic signed [15:0] rx,
                              input logic signed [15:0] ry,
                              input logic signed [15:0] rz,
                              input logic [15:0] dt);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_axis_x_up   <= ax;
    in_axis_y_up   <= ay;
    in_axis_z_up   <= az;
    in_body_rate_x <= rx;
    in_body_rate_y <= ry;
    in_body_rate_z <= rz;
    in_elapsed_us  <= dt;
    do @(posedge clk); while (in_stall);
    if (kind != KIND_IGNORED) requests_sent++;
    if (kind == KIND_SAMPLE) samples_sent++;
  endtask

  // non-sample request with random payload
  task automatic send_control(input logic [1:0] kind);
    send_request(kind, rand_axis(), rand_axis(), rand_axis(), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // sample, mostly with one clear upward face, half of those with a strong yaw rate
  task automatic send_sample();
    logic signed [15:0] a [3];
    logic signed [15:0] w [3];
    logic [15:0]        dt;
    int                 lead;
    int                 mag;
    int                 v;
    if ($urandom_range(99) < 70) begin
      lead = $urandom_range(2);
      mag  = $urandom_range(8192, 16384);
      for (int k = 0; k < 3; k++) begin
        v = ($urandom_range(99) < 12) ? mag : int'($urandom_range(mag));
        a[k] = 16'($urandom_range(1) ? v : -v);
        w[k] = 16'($urandom);
      end
      a[lead] = 16'($urandom_range(1) ? mag : -mag);
      if ($urandom_range(1)) begin
        for (int k = 0; k < 3; k++) w[k] = small_signed(2048);
        v = $urandom_range(8192, 32767);
        w[lead] = ($urandom_range(9) == 0) ? 16'h8000 : 16'((a[lead] < 0) ? -v : v);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_axis();
        w[k] = 16'($urandom);
      end
    end
    case ($urandom_range(9))
      0:       dt = '0;
      1:       dt = '1;
      2, 3:    dt = 16'($urandom);
      default: dt = 16'($urandom_range(16384, 65535));
    endcase
    send_request(KIND_SAMPLE, a[0], a[1], a[2], w[0], w[1], w[2], dt);
  endtask

  // hold off until every result is back
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
  endtask

  // all four registers, write enable held across the burst
  task automatic load_config(input logic [RATE_W-1:0] lo_rate,
                             input logic [RATE_W-1:0] hi_rate,
                             input logic [THR_W-1:0] thr,
                             input logic [SAMP_W-1:0] samp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_RATE;
    cfg_wdata <= CFG_W'(lo_rate);
    @(posedge clk);
    cfg_index <= CFG_MAX_RATE;
    cfg_wdata <= CFG_W'(hi_rate);
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= CFG_MAX_SAMP;
    cfg_wdata <= CFG_W'(samp);
    @(posedge clk);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 79; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 79; end
      default: begin idle_pct = 23; stall_pct <= 23; end
    endcase
  endtask

  // mostly start-led collection runs, some stray requests
  task automatic random_phase(input int quota);
    int first;
    int len;
    int r;
    first = requests_sent;
    while (requests_sent - first < quota) begin
      if ($urandom_range(99) < 8) wait_for_reports();
      if ($urandom_range(99) < 85) begin
        send_control(KIND_START);
        len = $urandom_range(1, 48);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 3) send_control(KIND_CANCEL);
          else if (r < 5) send_control(KIND_IGNORED);
          else if (r < 7) send_control(KIND_START);
          else send_sample();
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(3);
          if (r == KIND_SAMPLE) send_sample();
          else send_control(2'(r));
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle, ignored and control requests, face ties, rate extremes
    send_request(KIND_SAMPLE, 16384, 0, 0, 100, 100, 100, 500);
    send_request(KIND_IGNORED, -16384, 16384, -16384, -32768, 32767, -32768, 65535);
    send_request(KIND_CANCEL, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_START, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_SAMPLE, 16384, 0, 0, 32767, 0, 0, 65535);
    send_request(KIND_SAMPLE, 0, 0, 0, -32768, -32768, -32768, 65535);
    send_request(KIND_SAMPLE, -16384, 16384, 0, -32768, 32767, 0, 65535);
    send_request(KIND_SAMPLE, 0, 16384, 16384, 0, 32767, 32767, 65535);
    send_request(KIND_SAMPLE, 0, -16384, -16384, 0, -32768, 0, 0);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 65535);
    send_request(KIND_SAMPLE, 100, -200, -16384, 0, 0, -32768, 65535);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 1, 65535);
    send_request(KIND_IGNORED, 0, 0, 16384, 0, 0, 32767, 65535);
    send_request(KIND_CANCEL, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 65535);

    // directed: zero threshold, every face completes, then the sample limit
    wait_for_reports();
    load_config(15'd0, 15'd32767, 40'd0, 16'd8);
    send_request(KIND_START, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 1);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 1);
    send_request(KIND_SAMPLE, 0, 0, -16384, 0, 0, 32767, 1);
    send_request(KIND_SAMPLE, 16384, 0, 0, -32768, 0, 0, 1);
    send_request(KIND_SAMPLE, -16384, 0, 0, 32767, 0, 0, 1);
    send_request(KIND_SAMPLE, 0, 16384, 0, 0, 32767, 0, 1);
    send_request(KIND_SAMPLE, 0, -16384, 0, 0, 32767, 0, 1);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 65535);
    send_request(KIND_SAMPLE, 0, 0, 16384, 0, 0, 32767, 65535);

    // random phases over several settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      wait_for_reports();
      case (p)
        0: load_config(15'd0, 15'd32767, 40'd1, 16'd1);
        1: load_config(15'd410, 15'd20000, 40'd2_000_000_000, 16'd40);
        2: load_config(15'd32767, 15'd32767, 40'd1_000_000_000, 16'd65535);
        3: load_config(15'd100, 15'd0, 40'd5, 16'd30);
        5: load_config(15'd0, 15'd32767, 40'd0, 16'd50);
        7: load_config(15'd4096, 15'd16384, 40'd1_000_000_000, 16'd65535);
        default: load_config(15'($urandom_range(2000)), 15'($urandom_range(8192, 32767)),
                             40'($urandom_range(100_000_000, 2_000_000_000))
                               * 40'($urandom_range(1, 2)),
                             16'($urandom_range(20, 200)));
      endcase
      set_idle(p % 4);
      random_phase(135);
    end

    // one face pushed to the angle ceiling with the largest threshold
    wait_for_reports();
    load_config(15'd0, 15'd32767, 40'hFF_FFFF_FFFF, 16'd65535);
    set_idle(3);
    send_control(KIND_START);
    repeat (560) begin
      send_request(KIND_SAMPLE, small_signed(50), small_signed(50), 16384,
                   16'($urandom), 16'($urandom),
                   $urandom_range(1) ? 16'sd32767 : 16'h8000,
                   ($urandom_range(19) == 0) ? 16'($urandom) : 16'hFFFF);
    end

    // drain and let the block settle
    wait_for_reports();
    set_idle(0);
    repeat (40) @(posedge clk);

    $display("%0d requests (%0d samples) over %0d register settings, %0d results checked",
             requests_sent, samples_sent, phases_run, reports_checked);
    $display("all faces complete in %0d results, sample limit in %0d, one ceiling run",
             full_coverage_seen, limit_hits_seen);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
